// ===== rtl/dual_accel_tilt_estimator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the tilt estimator RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_ACCEL_TILT_ESTIMATOR_ASSERT_SVH
`define DUAL_ACCEL_TILT_ESTIMATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DAT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DAT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DAT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/dat_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt estimator package
// Item types, register map, arctangent table and saturation helper.
// ----------------------------------------------------------------------------
package dat_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int NUM_CFG  = 8;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_W    = 64;

   localparam int CFG_ACCEL_X1 = 0;
   localparam int CFG_ACCEL_X2 = 1;
   localparam int CFG_ACCEL_Y1 = 2;
   localparam int CFG_ACCEL_Y2 = 3;
   localparam int CFG_GYRO1    = 4;
   localparam int CFG_GYRO2    = 5;
   localparam int CFG_YAW      = 6;
   localparam int CFG_GEOMETRY = 7;

   localparam logic [CFG_W-1:0] CFG_UNITY = 64'h0100_0000_0000_0000;

   localparam int AB_W = 41;
   localparam int XY_W = 44;
   localparam int Z_W  = 35;

   localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

   localparam logic [29:0] ATAN_TAB [32] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
   };

   typedef struct packed {
      logic signed [15:0] raw_accel_x1;
      logic signed [15:0] raw_accel_x2;
      logic signed [15:0] raw_accel_y1;
      logic signed [15:0] raw_accel_y2;
      logic signed [15:0] raw_tilt_rate1;
      logic signed [15:0] raw_tilt_rate2;
      logic signed [15:0] raw_yaw_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] tilt_angle;
      logic signed [31:0] tilt_rate;
      logic signed [31:0] tilt_accel;
      logic signed [31:0] yaw_rate;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] rate;
      logic signed [31:0] accel;
      logic signed [31:0] yaw;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -72'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return signed'(v[31:0]);
      end
   endfunction

endpackage

// ===== rtl/dat_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface dat_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dat_cordic.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// Half-plane fold, then one register stage per rotation step.
// ----------------------------------------------------------------------------
module dat_cordic #(
   parameter int STEPS = dat_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [dat_pkg::AB_W-1:0]   in_a,
   input  logic signed [dat_pkg::AB_W-1:0]   in_b,
   input  dat_pkg::side_type                 in_side,
   output logic                              out_valid,
   output logic signed [dat_pkg::Z_W-1:0]    out_z,
   output logic                              out_zero,
   output dat_pkg::side_type                 out_side
);
   import dat_pkg::*;

   logic                   v_ff    [STEPS+1];
   logic                   zero_ff [STEPS+1];
   logic signed [XY_W-1:0] x_ff    [STEPS+1];
   logic signed [XY_W-1:0] y_ff    [STEPS+1];
   logic signed [Z_W-1:0]  z_ff    [STEPS+1];
   side_type               side_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= (in_a == '0) && (in_b == '0);
         side_ff[0] <= in_side;
         if (in_b < 0) begin
            x_ff[0] <= -XY_W'(in_b);
            y_ff[0] <= -XY_W'(in_a);
            z_ff[0] <= (in_a >= 0) ? PI_Q30 : -PI_Q30;
         end else begin
            x_ff[0] <= XY_W'(in_b);
            y_ff[0] <= XY_W'(in_a);
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TAB[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff[k+1] <= zero_ff[k];
            side_ff[k+1] <= side_ff[k];
            if (y_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + ANG;
            end else begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - ANG;
            end
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_z     = z_ff[STEPS];
   assign out_zero  = zero_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

// ===== rtl/dual_accel_tilt_estimator.sv =====
// ----------------------------------------------------------------------------
// Dual accelerometer tilt estimator
// Calibrates seven raw channels and produces tilt angle, tilt rate,
// tilt acceleration and yaw rate in Q16.16.
// ----------------------------------------------------------------------------
// Pipeline: 4 calibration stages, CORDIC fold, one stage per CORDIC
// step, output register.
// Throughput: one item per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset clears all valid bits and loads the default calibration.
module dual_accel_tilt_estimator #(
   parameter int CORDIC_STEPS = dat_pkg::CORDIC_STEPS_DEF,
   parameter int SAMPLE_BITS  = dat_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   dat_stream_if.sink                      req_chan,
   dat_stream_if.source                    rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [dat_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [dat_pkg::CFG_W-1:0]       csr_data
);
   import dat_pkg::*;

   `include "dual_accel_tilt_estimator_assert.svh"

   logic [CFG_W-1:0] cfg_ff [NUM_CFG];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) begin
            cfg_ff[i] <= (i == CFG_GEOMETRY) ? '0 : CFG_UNITY;
         end
      end else if (csr_wr_en) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   logic adv;
   logic out_v_ff;
   rsp_type out_ff;

   assign adv = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   req_type req_p;
   assign req_p = req_chan.payload;

   logic signed [SAMPLE_BITS-1:0] smp [7];
   assign smp[0] = signed'(req_p.raw_accel_x1[SAMPLE_BITS-1:0]);
   assign smp[1] = signed'(req_p.raw_accel_x2[SAMPLE_BITS-1:0]);
   assign smp[2] = signed'(req_p.raw_accel_y1[SAMPLE_BITS-1:0]);
   assign smp[3] = signed'(req_p.raw_accel_y2[SAMPLE_BITS-1:0]);
   assign smp[4] = signed'(req_p.raw_tilt_rate1[SAMPLE_BITS-1:0]);
   assign smp[5] = signed'(req_p.raw_tilt_rate2[SAMPLE_BITS-1:0]);
   assign smp[6] = signed'(req_p.raw_yaw_rate[SAMPLE_BITS-1:0]);

   logic signed [31:0] gain [NUM_CFG];
   logic signed [31:0] offs [NUM_CFG];
   for (genvar r = 0; r < NUM_CFG; r++) begin : g_cfg
      assign gain[r] = signed'(cfg_ff[r][63:32]);
      assign offs[r] = signed'(cfg_ff[r][31:0]);
   end

   // stage 1: accel/yaw gain products, gyro offset sums
   logic                          v1_ff;
   logic signed [SAMPLE_BITS+31:0] p1_ff [4];
   logic signed [SAMPLE_BITS+31:0] py1_ff;
   logic signed [31:0]            s1_ff [2];

   // stage 2: calibrated accel/yaw, gyro gain products
   logic               v2_ff;
   logic signed [31:0] cal2_ff [4];
   logic signed [31:0] yaw2_ff;
   logic signed [63:0] gp2_ff [2];

   // stage 3: alpha products, x difference, calibrated gyros
   logic               v3_ff;
   logic signed [31:0] x1_3_ff;
   logic signed [31:0] y1_3_ff;
   logic signed [63:0] pa3_ff;
   logic signed [63:0] pb3_ff;
   logic signed [32:0] d3_ff;
   logic signed [31:0] g3_ff [2];
   logic signed [31:0] yaw3_ff;

   // stage 4: compensated vector, accel product, rate
   logic                   v4_ff;
   logic signed [AB_W-1:0] a4_ff;
   logic signed [AB_W-1:0] b4_ff;
   logic signed [64:0]     accp4_ff;
   logic signed [31:0]     rate4_ff;
   logic signed [31:0]     yaw4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            p1_ff[i]   <= smp[i] * gain[i];
            cal2_ff[i] <= sat32(72'(p1_ff[i] >>> 8) + 72'(offs[i]));
         end
         py1_ff <= smp[6] * gain[CFG_YAW];
         for (int j = 0; j < 2; j++) begin
            s1_ff[j]  <= sat32(72'(smp[4+j]) * 72'sd65536 + 72'(offs[CFG_GYRO1+j]));
            gp2_ff[j] <= s1_ff[j] * gain[CFG_GYRO1+j];
            g3_ff[j]  <= sat32(72'(gp2_ff[j] >>> 24));
         end
         yaw2_ff <= sat32(72'(py1_ff >>> 8) + 72'(offs[CFG_YAW]));

         x1_3_ff <= cal2_ff[0];
         y1_3_ff <= cal2_ff[2];
         pa3_ff  <= gain[CFG_GEOMETRY] * cal2_ff[1];
         pb3_ff  <= gain[CFG_GEOMETRY] * cal2_ff[3];
         d3_ff   <= 33'(cal2_ff[0]) - 33'(cal2_ff[1]);
         yaw3_ff <= yaw2_ff;

         a4_ff    <= AB_W'(x1_3_ff) - AB_W'(pa3_ff >>> 24);
         b4_ff    <= AB_W'(y1_3_ff) - AB_W'(pb3_ff >>> 24);
         accp4_ff <= d3_ff * offs[CFG_GEOMETRY];
         rate4_ff <= 32'((33'(g3_ff[0]) + 33'(g3_ff[1])) >>> 1);
         yaw4_ff  <= yaw3_ff;
      end
   end

   side_type               side4;
   logic                   cv;
   logic signed [Z_W-1:0]  cz;
   logic                   czero;
   side_type               cside;

   assign side4.rate  = rate4_ff;
   assign side4.accel = sat32(72'(accp4_ff >>> 16));
   assign side4.yaw   = yaw4_ff;

   dat_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_a      (a4_ff),
      .in_b      (b4_ff),
      .in_side   (side4),
      .out_valid (cv),
      .out_z     (cz),
      .out_zero  (czero),
      .out_side  (cside)
   );

   logic signed [Z_W:0]  zr;
   logic signed [31:0]   ang_in;
   assign zr     = (Z_W+1)'(cz) + (Z_W+1)'(8192);
   assign ang_in = czero ? '0 : -(32'(zr >>> 14));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= cv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.tilt_angle <= ang_in;
         out_ff.tilt_rate  <= cside.rate;
         out_ff.tilt_accel <= cside.accel;
         out_ff.yaw_rate   <= cside.yaw;
      end
   end

   assign rsp_chan.valid   = out_v_ff;
   assign rsp_chan.payload = out_ff;

   `DAT_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready)
   `DAT_ASSERT_NEXT(a_stall_holds_cordic, clock, reset, !adv, $stable(cv) && $stable(cz))
   `DAT_ASSERT_NEXT(a_zero_vector_angle, clock, reset, adv && cv && czero, rsp_chan.payload.tilt_angle == 32'sd0)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt estimator testbench
// Drives sample sets through the stream port under several calibration
// settings and flow-control patterns, and checks every result field against
// a fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
   import dat_pkg::*;

   localparam int DRAIN_CYCLES = CORDIC_STEPS_DEF + 16;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_data;

   dat_stream_if #(.payload_type(req_type)) req_if ();
   dat_stream_if #(.payload_type(rsp_type)) rsp_if ();

   dual_accel_tilt_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   logic [CFG_W-1:0] cal_reg [NUM_CFG];
   rsp_type pending_estimates [$];
   int error_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb: done, errors");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint gain_of(input int r);
      return longint'(signed'(cal_reg[r][63:32]));
   endfunction

   function automatic longint offset_of(input int r);
      return longint'(signed'(cal_reg[r][31:0]));
   endfunction

   function automatic longint scale_then_shift(input logic signed [15:0] raw, input int r);
      return clamp32(((longint'(raw) * gain_of(r)) >>> 8) + offset_of(r));
   endfunction

   function automatic longint shift_then_scale(input logic signed [15:0] raw, input int r);
      longint s;
      s = clamp32(longint'(raw) * 65536 + offset_of(r));
      return clamp32((s * gain_of(r)) >>> 24);
   endfunction

   function automatic longint vector_angle(input longint a, input longint b);
      longint x, y, z, nx;
      z = 0;
      if (a == 0 && b == 0) begin
         return 0;
      end
      x = b;
      y = a;
      if (b < 0) begin
         z = (a >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
         x = -b;
         y = -a;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic rsp_type estimate_tilt(input req_type s);
      longint x1, x2, y1, y2, g1, g2, yaw, alpha, inv_dr, a, b;
      rsp_type r;
      x1 = scale_then_shift(s.raw_accel_x1, CFG_ACCEL_X1);
      x2 = scale_then_shift(s.raw_accel_x2, CFG_ACCEL_X2);
      y1 = scale_then_shift(s.raw_accel_y1, CFG_ACCEL_Y1);
      y2 = scale_then_shift(s.raw_accel_y2, CFG_ACCEL_Y2);
      g1 = shift_then_scale(s.raw_tilt_rate1, CFG_GYRO1);
      g2 = shift_then_scale(s.raw_tilt_rate2, CFG_GYRO2);
      yaw = scale_then_shift(s.raw_yaw_rate, CFG_YAW);
      alpha = gain_of(CFG_GEOMETRY);
      inv_dr = offset_of(CFG_GEOMETRY);
      a = x1 - ((alpha * x2) >>> 24);
      b = y1 - ((alpha * y2) >>> 24);
      r.tilt_angle = 32'(-((vector_angle(a, b) + 8192) >>> 14));
      r.tilt_rate = 32'(clamp32((g1 + g2) >>> 1));
      r.tilt_accel = 32'(clamp32(((x1 - x2) * inv_dr) >>> 16));
      r.yaw_rate = 32'(yaw);
      return r;
   endfunction

   // ---------------- result side ----------------
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_estimates.size() == 0) begin
            $error("unexpected item %h", rsp_if.payload);
            error_count++;
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_if.payload.tilt_angle !== want.tilt_angle) begin
               $error("tilt_angle exp %0d got %0d", want.tilt_angle,
                      rsp_if.payload.tilt_angle);
               error_count++;
            end
            if (rsp_if.payload.tilt_rate !== want.tilt_rate) begin
               $error("tilt_rate exp %0d got %0d", want.tilt_rate,
                      rsp_if.payload.tilt_rate);
               error_count++;
            end
            if (rsp_if.payload.tilt_accel !== want.tilt_accel) begin
               $error("tilt_accel exp %0d got %0d", want.tilt_accel,
                      rsp_if.payload.tilt_accel);
               error_count++;
            end
            if (rsp_if.payload.yaw_rate !== want.yaw_rate) begin
               $error("yaw_rate exp %0d got %0d", want.yaw_rate,
                      rsp_if.payload.yaw_rate);
               error_count++;
            end
         end
      end
   end

   // ---------------- drive side ----------------
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_estimates.push_back(estimate_tilt(it));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_calibration(input logic [CFG_W-1:0] vals [NUM_CFG]);
      wait_idle();
      for (int i = 0; i < NUM_CFG; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CFG_IDX_W'(i);
         csr_data <= vals[i];
         cal_reg[i] = vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(64)) - 32);
         3: return 16'($signed($urandom_range(2000)) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type it;
      it.raw_accel_x1 = rand_sample();
      it.raw_accel_x2 = rand_sample();
      it.raw_accel_y1 = rand_sample();
      it.raw_accel_y2 = rand_sample();
      it.raw_tilt_rate1 = rand_sample();
      it.raw_tilt_rate2 = rand_sample();
      it.raw_yaw_rate = rand_sample();
      return it;
   endfunction

   // gain near unity (sometimes negated) and modest offset most of the time, raw bits otherwise
   function automatic logic [CFG_W-1:0] rand_cal();
      logic [31:0] g, o;
      if ($urandom_range(3) == 0) begin
         return {$urandom, $urandom};
      end
      g = 32'h0100_0000 + 32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
      if ($urandom_range(4) == 0) g = -g;
      o = 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      return {g, o};
   endfunction

   function automatic req_type make_item(input int x1, input int x2, input int y1,
                                         input int y2, input int g1, input int g2,
                                         input int yw);
      req_type it;
      it.raw_accel_x1 = 16'(x1);
      it.raw_accel_x2 = 16'(x2);
      it.raw_accel_y1 = 16'(y1);
      it.raw_accel_y2 = 16'(y2);
      it.raw_tilt_rate1 = 16'(g1);
      it.raw_tilt_rate2 = 16'(g2);
      it.raw_yaw_rate = 16'(yw);
      return it;
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      logic [CFG_W-1:0] v [NUM_CFG];
      for (int i = 0; i < NUM_CFG; i++) v[i] = CFG_UNITY;
      v[CFG_GEOMETRY] = 64'h0000_0000_0001_0000;
      load_calibration(v);
      send_item(make_item(0, 0, 0, 0, 0, 0, 0));            // zero vector
      send_item(make_item(0, 0, -5, 0, 1, 2, 3));           // -pi case
      send_item(make_item(5, 0, -5, 0, -1, -2, -3));
      send_item(make_item(-5, 0, -5, 0, 7, -7, 9));
      send_item(make_item(100, 0, 0, 0, 0, 0, 0));
      send_item(make_item(-100, 0, 0, 0, 0, 0, 0));
      send_item(make_item(0, 0, 100, 0, 0, 0, 0));
      send_item(make_item(32767, -32768, 32767, -32768, 32767, 32767, 32767));
      send_item(make_item(-32768, 32767, -32768, 32767, -32768, -32768, -32768));
      send_item(make_item(-1, -1, -1, -1, -1, -1, -1));
      // saturation: largest gains and offsets
      for (int i = 0; i < NUM_CFG; i++) v[i] = 64'h7fff_ffff_7fff_ffff;
      load_calibration(v);
      send_item(make_item(32767, -32768, 32767, 1, 32767, 32767, 32767));
      send_item(make_item(-32768, 32767, -32768, -1, -32768, -32768, -32768));
      send_item(make_item(0, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < NUM_CFG; i++) v[i] = 64'h8000_0000_8000_0000;
      load_calibration(v);
      send_item(make_item(32767, -32768, 32767, 1, 32767, 32767, 32767));
      send_item(make_item(-32768, 32767, -32768, -1, -32768, -32768, -32768));
      send_item(make_item(0, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < NUM_CFG; i++) v[i] = '0;
      load_calibration(v);
      send_item(make_item(1234, -99, 77, 5, 6, 7, 8));
      for (int i = 0; i < NUM_CFG; i++) v[i] = '1;
      load_calibration(v);
      send_item(make_item(1234, -99, 77, 5, 6, 7, 8));
      send_item(make_item(-32768, 32767, 32767, -32768, 32767, -32768, 1));
   endtask

   task automatic test_random_phase(input int idle, input int stall, input int items);
      logic [CFG_W-1:0] v [NUM_CFG];
      for (int i = 0; i < NUM_CFG; i++) v[i] = rand_cal();
      load_calibration(v);
      idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         send_item(rand_item());
         if (n % 110 == 109) begin
            for (int i = 0; i < NUM_CFG; i++) v[i] = rand_cal();
            load_calibration(v);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      for (int i = 0; i < NUM_CFG; i++) cal_reg[i] = (i == CFG_GEOMETRY) ? '0 : CFG_UNITY;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_item(make_item(300, 200, -400, 100, 50, -50, 10));  // reset calibration
      test_directed();
      test_random_phase(0, 0, 320);
      test_random_phase(52, 0, 310);
      test_random_phase(0, 52, 310);
      test_random_phase(35, 35, 310);
      idle_pct = 0;
      stall_pct = 0;
      wait_idle();
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
